// ===== rtl/lsb_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the limit switch back-off supervisor
// no dependencies; imported by every module of the block
package lsb_pkg;

	// item kinds carried on the slave tuser
	typedef enum logic [1:0] {
		OP_TICK    = 2'd0,
		OP_CHECK   = 2'd1,
		OP_STOPPED = 2'd2
	} lsb_op_t;

	// supervisor states, one-hot
	typedef enum logic [6:0] {
		ST_IDLE     = 7'b0000001,
		ST_AT_MIN   = 7'b0000010,
		ST_AT_MAX   = 7'b0000100,
		ST_WAIT_MIN = 7'b0001000,
		ST_WAIT_MAX = 7'b0010000,
		ST_OFF_MIN  = 7'b0100000,
		ST_OFF_MAX  = 7'b1000000
	} lsb_state_t;

	// reported state codes
	localparam logic [2:0] CODE_IDLE     = 3'd0;
	localparam logic [2:0] CODE_AT_MIN   = 3'd1;
	localparam logic [2:0] CODE_AT_MAX   = 3'd2;
	localparam logic [2:0] CODE_WAIT_MIN = 3'd3;
	localparam logic [2:0] CODE_WAIT_MAX = 3'd4;
	localparam logic [2:0] CODE_OFF_MIN  = 3'd5;
	localparam logic [2:0] CODE_OFF_MAX  = 3'd6;

	// stop request codes
	localparam logic [1:0] STOP_NONE      = 2'd0;
	localparam logic [1:0] STOP_SLEW      = 2'd1;
	localparam logic [1:0] STOP_SLEW_TRK  = 2'd2;
	localparam logic [1:0] STOP_TRK       = 2'd3;

	// configuration register indexes
	localparam logic [1:0] REG_ACTIVE_LEVEL     = 2'd0;
	localparam logic [1:0] REG_AXIS_IS_RA       = 2'd1;
	localparam logic [1:0] REG_BACKOFF_DEGREES  = 2'd2;
	localparam logic [1:0] REG_STEPS_PER_DEGREE = 2'd3;

	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned WORD_W     = 40;

	typedef struct packed {
		logic        active_level;
		logic        axis_is_ra;
		logic [7:0]  backoff_degrees;
		logic [15:0] steps_per_degree;
	} lsb_cfg_t;

	typedef struct packed {
		logic [1:0]         operation;
		logic               min_switch_level;
		logic               max_switch_level;
		logic signed [31:0] position;
		logic               slewing;
		logic               tracking;
	} lsb_item_t;

	typedef struct packed {
		logic [1:0]         stop_request;
		logic               move_valid;
		logic signed [31:0] move_distance;
		logic [2:0]         state_code;
	} lsb_result_t;

	function automatic logic [2:0] state_to_code(input lsb_state_t st);
		logic [2:0] code;
		case (st)
			ST_IDLE:     code = CODE_IDLE;
			ST_AT_MIN:   code = CODE_AT_MIN;
			ST_AT_MAX:   code = CODE_AT_MAX;
			ST_WAIT_MIN: code = CODE_WAIT_MIN;
			ST_WAIT_MAX: code = CODE_WAIT_MAX;
			ST_OFF_MIN:  code = CODE_OFF_MIN;
			ST_OFF_MAX:  code = CODE_OFF_MAX;
			default:     code = CODE_IDLE;
		endcase
		return code;
	endfunction

endpackage

// ===== rtl/lsb_calc.sv =====
`timescale 1ns / 1ps
// back-off distance: overrun plus signed extra steps, saturated to 32 bits
// depends on lsb_pkg
module lsb_calc (
	input  logic signed [31:0] trigger_position,
	input  logic signed [31:0] position,
	input  lsb_pkg::lsb_cfg_t  cfg,
	output logic signed [31:0] distance
);
	import lsb_pkg::*;

	logic signed [32:0] over;
	logic [23:0]        extra;
	logic signed [33:0] over_w;
	logic signed [33:0] extra_w;
	logic signed [33:0] dist_w;

	always_comb begin
		over    = 33'(trigger_position) - 33'(position);
		extra   = 24'(cfg.backoff_degrees) * 24'(cfg.steps_per_degree);
		over_w  = 34'(over);
		extra_w = $signed({10'd0, extra});
		if (over > 33'sd0) begin
			dist_w = over_w + extra_w;
		end else if (over < 33'sd0) begin
			dist_w = over_w - extra_w;
		end else begin
			dist_w = '0;
		end
		// saturate to signed 32 bits
		if (dist_w > 34'sh0_7FFF_FFFF) begin
			distance = 32'sh7FFF_FFFF;
		end else if (dist_w < -34'sh0_8000_0000) begin
			distance = 32'sh8000_0000;
		end else begin
			distance = dist_w[31:0];
		end
	end

endmodule

// ===== rtl/lsb_fsm.sv =====
`timescale 1ns / 1ps
// limit state machine and trigger position latch, one item per advance
// depends on lsb_pkg and lsb_calc
module lsb_fsm (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 advance,
	input  lsb_pkg::lsb_item_t   item,
	input  lsb_pkg::lsb_cfg_t    cfg,
	output lsb_pkg::lsb_result_t result
);
	import lsb_pkg::*;

	lsb_state_t         state_q, state_d;
	logic signed [31:0] trig_q, trig_d;
	logic signed [31:0] distance;
	logic               min_on, max_on;

	lsb_calc u_calc (
		.trigger_position (trig_q),
		.position         (item.position),
		.cfg              (cfg),
		.distance         (distance)
	);

	always_comb begin
		state_d = state_q;
		trig_d  = trig_q;
		min_on  = (item.min_switch_level == cfg.active_level);
		max_on  = (item.max_switch_level == cfg.active_level);
		result.stop_request  = STOP_NONE;
		result.move_valid    = 1'b0;
		result.move_distance = '0;
		case (item.operation)
			OP_TICK: begin
				case (state_q)
					ST_IDLE: begin
						// max switch wins when both are pressed
						if (max_on) begin
							state_d = ST_AT_MAX;
							trig_d  = item.position;
						end else if (min_on) begin
							state_d = ST_AT_MIN;
							trig_d  = item.position;
						end
					end
					ST_OFF_MIN: if (!min_on) state_d = ST_IDLE;
					ST_OFF_MAX: if (!max_on) state_d = ST_IDLE;
					default: ;
				endcase
			end
			OP_CHECK: begin
				if (state_q == ST_AT_MIN || state_q == ST_AT_MAX) begin
					if (item.slewing) begin
						if (state_q == ST_AT_MAX) begin
							result.stop_request = cfg.axis_is_ra ? STOP_SLEW_TRK : STOP_SLEW;
							state_d = ST_WAIT_MAX;
						end else begin
							result.stop_request = STOP_SLEW;
							state_d = ST_WAIT_MIN;
						end
					end else if (state_q == ST_AT_MAX && item.tracking) begin
						result.stop_request = STOP_TRK;
						state_d = ST_OFF_MAX;
					end else if (state_q == ST_AT_MIN) begin
						state_d = ST_OFF_MIN;
					end
				end
			end
			OP_STOPPED: begin
				if (state_q == ST_WAIT_MIN || state_q == ST_WAIT_MAX) begin
					result.move_valid    = 1'b1;
					result.move_distance = distance;
					state_d = (state_q == ST_WAIT_MIN) ? ST_OFF_MIN : ST_OFF_MAX;
				end
			end
			default: ;
		endcase
		result.state_code = state_to_code(state_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			trig_q  <= '0;
		end else if (advance) begin
			state_q <= state_d;
			trig_q  <= trig_d;
		end
	end

endmodule

// ===== rtl/axis_limit_switch_backoff_top.sv =====
`timescale 1ns / 1ps
// top level of the limit switch back-off supervisor: ports, config, pipeline
// depends on lsb_pkg, lsb_fsm (which uses lsb_calc)
//
// usage
//  - slave stream takes one word per item: tick (sample switches and position),
//    check (motion flags) or stopped report (final position); kind on s_tuser
//  - master stream gives exactly one result word per item, in order
//  - config port: cfg_we with cfg_index 0 active_level, 1 axis_is_ra,
//    2 backoff_degrees, 3 steps_per_degree; write only while no item is in flight
//  - two register stages: input register then result register, so a result word
//    is offered on the master side from the result register
//  - one word per cycle while m_tready is high; state update, 8x16 multiply,
//    34-bit add and saturation sit in the single stage between the registers
//  - a stalled master (m_tready low) keeps its word; the input register still
//    fills, and s_tready drops only when both registers hold words
//  - reset (arst_n low) empties both stages, returns to idle with a zero
//    trigger position and loads the register defaults
module axis_limit_switch_backoff_top (
	input  logic        clk,
	input  logic        arst_n,
	// slave stream
	input  logic        s_tvalid,
	output logic        s_tready,
	// [0] min_switch_level, [1] max_switch_level, [33:2] position,
	// [34] slewing, [35] tracking, [39:36] zero
	input  logic [lsb_pkg::WORD_W-1:0] s_tdata,
	// [1:0] operation
	input  logic [1:0]  s_tuser,
	// master stream
	output logic        m_tvalid,
	input  logic        m_tready,
	// [1:0] stop_request, [2] move_valid, [34:3] move_distance,
	// [37:35] state_code, [39:38] zero
	output logic [lsb_pkg::WORD_W-1:0] m_tdata,
	// configuration write port
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [lsb_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import lsb_pkg::*;

	lsb_cfg_t    cfg_q;
	lsb_item_t   item_s1;
	logic        valid_s1;
	lsb_result_t res_s2;
	lsb_result_t res_d;
	logic        valid_s2;
	logic        adv_s1;    // stage 1 word moves to the result register
	logic        take_in;   // slave word accepted

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.active_level     <= 1'b0;
			cfg_q.axis_is_ra       <= 1'b1;
			cfg_q.backoff_degrees  <= 8'd2;
			cfg_q.steps_per_degree <= 16'd1000;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ACTIVE_LEVEL:     cfg_q.active_level     <= cfg_wdata[0];
				REG_AXIS_IS_RA:       cfg_q.axis_is_ra       <= cfg_wdata[0];
				REG_BACKOFF_DEGREES:  cfg_q.backoff_degrees  <= cfg_wdata[7:0];
				REG_STEPS_PER_DEGREE: cfg_q.steps_per_degree <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	// flow control: the result register frees when empty or taken this cycle
	assign adv_s1   = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv_s1;
	assign take_in  = s_tvalid && s_tready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			item_s1.operation        <= s_tuser;
			item_s1.min_switch_level <= s_tdata[0];
			item_s1.max_switch_level <= s_tdata[1];
			item_s1.position         <= s_tdata[33:2];
			item_s1.slewing          <= s_tdata[34];
			item_s1.tracking         <= s_tdata[35];
		end
	end

	// state machine commits its update only when the word moves on
	lsb_fsm u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.advance(adv_s1),
		.item   (item_s1),
		.cfg    (cfg_q),
		.result (res_d)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res_d;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {2'b00, res_s2.state_code, res_s2.move_distance,
		res_s2.move_valid, res_s2.stop_request};

endmodule

// ===== test/axis_limit_switch_backoff_top_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the limit switch back-off supervisor top level
// depends on lsb_pkg and axis_limit_switch_backoff_top; streams directed and
// state-aware random words through the block and checks every result word
module axis_limit_switch_backoff_top_tb;
	import lsb_pkg::*;

	// the operation field is two bits wide, so the unused kind is legal stimulus
	localparam logic [1:0] OP_RESERVED = 2'd3;

	localparam longint DIST_CEIL  = 64'sd2147483647;
	localparam longint DIST_FLOOR = -64'sd2147483648;

	// one line of the directed table: the word to send and, where it is
	// obvious, the result word typed in by hand
	typedef struct packed {
		lsb_item_t   item;
		logic        typed;
		lsb_result_t answer;
	} step_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [WORD_W-1:0]     s_tdata;
	logic [1:0]            s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [WORD_W-1:0]     m_tdata;
	logic                  cfg_we;
	logic [1:0]            cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	// supervisor copy: settings, state code and latched position
	lsb_cfg_t           cfg_copy;
	logic [2:0]         axis_code;
	logic signed [31:0] trig_pos;

	lsb_result_t pending_results[$];
	int          mismatch_count = 0;

	// idling controls shared by the sender, the receiver and the sequence
	bit tx_idle_en    = 1'b0;
	bit rx_idle_en    = 1'b0;
	bit hold_off_req  = 1'b0;

	axis_limit_switch_backoff_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// safety net: well beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("axis_limit_switch_backoff_top test failed");
		$finish;
	end

	// supervisor prediction: applies one word to the local state copy and
	// returns the result word that the block must produce for it
	task automatic supervise_item(input lsb_item_t it, output lsb_result_t res);
		longint overrun;
		longint extra;
		longint move_dist;
		logic   pressed;
		pressed = cfg_copy.active_level;
		res = '0;
		case (it.operation)
			OP_TICK: begin
				if (axis_code == CODE_IDLE) begin
					// max is checked last so it wins when both are pressed
					if (it.min_switch_level == pressed) begin
						axis_code = CODE_AT_MIN;
						trig_pos = it.position;
					end
					if (it.max_switch_level == pressed) begin
						axis_code = CODE_AT_MAX;
						trig_pos = it.position;
					end
				end else if (axis_code == CODE_OFF_MIN && it.min_switch_level != pressed) begin
					axis_code = CODE_IDLE;
				end else if (axis_code == CODE_OFF_MAX && it.max_switch_level != pressed) begin
					axis_code = CODE_IDLE;
				end
			end
			OP_CHECK: begin
				if (axis_code == CODE_AT_MIN || axis_code == CODE_AT_MAX) begin
					if (it.slewing) begin
						res.stop_request = (axis_code == CODE_AT_MAX && cfg_copy.axis_is_ra) ?
							STOP_SLEW_TRK : STOP_SLEW;
						axis_code = (axis_code == CODE_AT_MIN) ? CODE_WAIT_MIN : CODE_WAIT_MAX;
					end else if (axis_code == CODE_AT_MAX && it.tracking) begin
						res.stop_request = STOP_TRK;
						axis_code = CODE_OFF_MAX;
					end else if (axis_code == CODE_AT_MIN) begin
						axis_code = CODE_OFF_MIN;
					end
				end
			end
			OP_STOPPED: begin
				if (axis_code == CODE_WAIT_MIN || axis_code == CODE_WAIT_MAX) begin
					overrun = longint'($signed(trig_pos)) - longint'($signed(it.position));
					extra = longint'(cfg_copy.backoff_degrees) *
						longint'(cfg_copy.steps_per_degree);
					if (overrun > 0)
						move_dist = overrun + extra;
					else if (overrun < 0)
						move_dist = overrun - extra;
					else
						move_dist = 0;
					if (move_dist > DIST_CEIL)
						move_dist = DIST_CEIL;
					if (move_dist < DIST_FLOOR)
						move_dist = DIST_FLOOR;
					res.move_valid = 1'b1;
					res.move_distance = move_dist[31:0];
					axis_code = (axis_code == CODE_WAIT_MIN) ? CODE_OFF_MIN : CODE_OFF_MAX;
				end
			end
			default: begin
			end
		endcase
		res.state_code = axis_code;
	endtask

	function automatic step_row_t step_row(input logic [1:0] op, input logic lvl_min,
		input logic lvl_max, input logic signed [31:0] pos, input logic slew,
		input logic trk, input logic typed, input logic [1:0] stop, input logic mv,
		input logic signed [31:0] distance, input logic [2:0] code);
		step_row_t r;
		r.item.operation = op;
		r.item.min_switch_level = lvl_min;
		r.item.max_switch_level = lvl_max;
		r.item.position = pos;
		r.item.slewing = slew;
		r.item.tracking = trk;
		r.typed = typed;
		r.answer.stop_request = stop;
		r.answer.move_valid = mv;
		r.answer.move_distance = distance;
		r.answer.state_code = code;
		return r;
	endfunction

	// offer one word, possibly after a random gap, and record its result
	// once it has been taken; valid is left high for a back-to-back word
	task automatic present_word(input lsb_item_t it, input logic typed,
		input lsb_result_t typed_res);
		int          gap;
		lsb_result_t predicted;
		if (tx_idle_en && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 19);
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= it.operation;
		s_tdata  <= {4'b0, it.tracking, it.slewing, it.position,
			it.max_switch_level, it.min_switch_level};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		supervise_item(it, predicted);
		pending_results.push_back(typed ? typed_res : predicted);
	endtask

	// stop sending and wait until every outstanding result word is back
	task automatic drain_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// write all four registers; unused upper data bits carry noise
	task automatic load_settings(input logic level, input logic ra,
		input logic [7:0] deg, input logic [15:0] spd);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_ACTIVE_LEVEL;
		cfg_wdata <= {15'($urandom), level};
		@(negedge clk);
		cfg_index <= REG_AXIS_IS_RA;
		cfg_wdata <= {15'($urandom), ra};
		@(negedge clk);
		cfg_index <= REG_BACKOFF_DEGREES;
		cfg_wdata <= {8'($urandom), deg};
		@(negedge clk);
		cfg_index <= REG_STEPS_PER_DEGREE;
		cfg_wdata <= spd;
		@(negedge clk);
		cfg_we <= 1'b0;
		cfg_copy.active_level     = level;
		cfg_copy.axis_is_ra       = ra;
		cfg_copy.backoff_degrees  = deg;
		cfg_copy.steps_per_degree = spd;
	endtask

	// next random word, steered by the predicted state so that most words
	// walk the trigger / stop / back-off / release sequence
	task automatic pick_next_item(output lsb_item_t it);
		logic pressed;
		pressed = cfg_copy.active_level;
		it.operation        = OP_TICK;
		it.min_switch_level = 1'($urandom);
		it.max_switch_level = 1'($urandom);
		it.position         = $urandom;
		it.slewing          = 1'($urandom);
		it.tracking         = 1'($urandom);
		// plain noise: any kind, any content
		if ($urandom_range(0, 6) == 0) begin
			it.operation = 2'($urandom_range(0, 3));
			return;
		end
		if ($urandom_range(0, 1) == 0)
			it.position = int'($urandom_range(0, 20000)) - 10000;
		case (axis_code)
			CODE_IDLE: begin
				it.min_switch_level = ($urandom_range(0, 2) == 0) ? pressed : ~pressed;
				it.max_switch_level = ($urandom_range(0, 2) == 0) ? pressed : ~pressed;
			end
			CODE_AT_MIN, CODE_AT_MAX: begin
				if ($urandom_range(0, 4) != 0)
					it.operation = OP_CHECK;
				it.slewing = ($urandom_range(0, 2) != 0);
			end
			CODE_WAIT_MIN, CODE_WAIT_MAX: begin
				if ($urandom_range(0, 4) == 0) begin
					it.operation = ($urandom_range(0, 1) == 0) ? OP_TICK : OP_CHECK;
				end else begin
					it.operation = OP_STOPPED;
					case ($urandom_range(0, 7))
						0: it.position = trig_pos;
						1: it.position = $urandom;
						2: it.position = trig_pos ^ 32'h8000_0000;
						default: it.position = trig_pos - (int'($urandom_range(0, 4000)) - 2000);
					endcase
				end
			end
			default: begin
				// backing off: tick with switches released about half the time
			end
		endcase
	endtask

	task automatic report_fault(input string msg);
		if (mismatch_count < 10)
			$display("%0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// result checker: every accepted result word against the oldest prediction
	always @(posedge clk) begin : result_check
		lsb_result_t got;
		lsb_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.stop_request  = m_tdata[1:0];
			got.move_valid    = m_tdata[2];
			got.move_distance = m_tdata[34:3];
			got.state_code    = m_tdata[37:35];
			if (pending_results.size() == 0) begin
				report_fault($sformatf("unexpected result word %h", m_tdata));
			end else begin
				want = pending_results.pop_front();
				if (got.stop_request !== want.stop_request ||
					got.move_valid !== want.move_valid ||
					got.move_distance !== want.move_distance ||
					got.state_code !== want.state_code)
					report_fault($sformatf(
						"mismatch exp stop %0d mv %0d dist %0d state %0d, got stop %0d mv %0d dist %0d state %0d",
						want.stop_request, want.move_valid, want.move_distance, want.state_code,
						got.stop_request, got.move_valid, got.move_distance, got.state_code));
			end
		end
	end

	// receiver: random stall bursts, plus one long hold-off on request so the
	// two register stages fill and the slave side is pushed back
	initial begin : receiver
		int stall_left;
		stall_left = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (hold_off_req) begin
				hold_off_req = 1'b0;
				stall_left = 79;
				m_tready <= 1'b0;
			end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 19) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		step_row_t   directed_rows[$];
		lsb_item_t   it;
		lsb_result_t none;
		int          phase;
		int          sent;
		int          useful;

		// every input known from time zero, reset held low at the start
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = OP_TICK;
		cfg_we    = 1'b0;
		cfg_index = REG_ACTIVE_LEVEL;
		cfg_wdata = '0;
		none      = '0;

		cfg_copy.active_level     = 1'b0;
		cfg_copy.axis_is_ra       = 1'b1;
		cfg_copy.backoff_degrees  = 8'd2;
		cfg_copy.steps_per_degree = 16'd1000;
		axis_code = CODE_IDLE;
		trig_pos  = '0;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed sequence at the reset settings: pressed level 0, ra axis,
		// 2 degrees of 1000 steps
		// op, min, max, position, slew, track, typed, stop, move, distance, state
		directed_rows.push_back(step_row(OP_CHECK, 1, 1, 0, 1, 1,
			1, STOP_NONE, 0, 0, CODE_IDLE));                   // check away from a limit
		directed_rows.push_back(step_row(OP_STOPPED, 1, 1, 5, 0, 0,
			1, STOP_NONE, 0, 0, CODE_IDLE));                   // stray stop report
		directed_rows.push_back(step_row(OP_RESERVED, 0, 0, -1, 1, 1,
			1, STOP_NONE, 0, 0, CODE_IDLE));                   // unused kind
		directed_rows.push_back(step_row(OP_TICK, 1, 1, 123, 0, 0,
			1, STOP_NONE, 0, 0, CODE_IDLE));                   // both released
		directed_rows.push_back(step_row(OP_TICK, 0, 0, 32'sh7fff_ffff, 0, 0,
			1, STOP_NONE, 0, 0, CODE_AT_MAX));                 // both pressed, max wins
		directed_rows.push_back(step_row(OP_CHECK, 0, 0, 0, 0, 0,
			1, STOP_NONE, 0, 0, CODE_AT_MAX));                 // at max, no motion
		directed_rows.push_back(step_row(OP_CHECK, 1, 1, 0, 1, 1,
			1, STOP_SLEW_TRK, 0, 0, CODE_WAIT_MAX));           // ra slew at max
		directed_rows.push_back(step_row(OP_TICK, 1, 1, 0, 0, 0,
			0, STOP_NONE, 0, 0, CODE_IDLE));
		directed_rows.push_back(step_row(OP_CHECK, 0, 0, 0, 1, 1,
			0, STOP_NONE, 0, 0, CODE_IDLE));
		directed_rows.push_back(step_row(OP_STOPPED, 0, 0, 32'sh8000_0000, 0, 0,
			1, STOP_NONE, 1, 32'sh7fff_ffff, CODE_OFF_MAX));   // positive saturation
		directed_rows.push_back(step_row(OP_TICK, 0, 0, 0, 0, 0,
			0, STOP_NONE, 0, 0, CODE_IDLE));
		directed_rows.push_back(step_row(OP_TICK, 0, 1, 0, 0, 0,
			0, STOP_NONE, 0, 0, CODE_IDLE));
		directed_rows.push_back(step_row(OP_TICK, 0, 1, 32'sh8000_0000, 0, 0,
			1, STOP_NONE, 0, 0, CODE_AT_MIN));
		directed_rows.push_back(step_row(OP_CHECK, 0, 0, 0, 0, 1,
			1, STOP_NONE, 0, 0, CODE_OFF_MIN));                // at min, not slewing
		directed_rows.push_back(step_row(OP_TICK, 1, 0, 0, 0, 0,
			0, STOP_NONE, 0, 0, CODE_IDLE));
		directed_rows.push_back(step_row(OP_TICK, 0, 1, 100, 0, 0,
			0, STOP_NONE, 0, 0, CODE_IDLE));
		directed_rows.push_back(step_row(OP_CHECK, 0, 0, 0, 1, 0,
			1, STOP_SLEW, 0, 0, CODE_WAIT_MIN));
		directed_rows.push_back(step_row(OP_STOPPED, 0, 0, 100, 0, 0,
			1, STOP_NONE, 1, 0, CODE_OFF_MIN));                // zero overrun
		directed_rows.push_back(step_row(OP_TICK, 1, 1, 0, 0, 0,
			0, STOP_NONE, 0, 0, CODE_IDLE));
		directed_rows.push_back(step_row(OP_TICK, 1, 0, 32'sh8000_0000, 0, 0,
			0, STOP_NONE, 0, 0, CODE_IDLE));
		directed_rows.push_back(step_row(OP_CHECK, 1, 1, 0, 0, 1,
			1, STOP_TRK, 0, 0, CODE_OFF_MAX));                 // tracking at max
		directed_rows.push_back(step_row(OP_TICK, 1, 1, 0, 0, 0,
			0, STOP_NONE, 0, 0, CODE_IDLE));
		directed_rows.push_back(step_row(OP_TICK, 1, 0, 32'sh8000_0005, 0, 0,
			0, STOP_NONE, 0, 0, CODE_IDLE));
		directed_rows.push_back(step_row(OP_CHECK, 0, 0, 0, 1, 0,
			0, STOP_NONE, 0, 0, CODE_IDLE));
		directed_rows.push_back(step_row(OP_STOPPED, 0, 0, 32'sh7fff_ffff, 0, 0,
			1, STOP_NONE, 1, 32'sh8000_0000, CODE_OFF_MAX));   // negative saturation

		foreach (directed_rows[i])
			present_word(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].answer);

		// random part: five settings, extremes first, the last one without idling
		for (phase = 0; phase < 5; phase++) begin
			drain_results();
			case (phase)
				0: load_settings(1'b1, 1'b0, 8'd255, 16'hffff);
				1: load_settings(1'b0, 1'b1, 8'd0, 16'd0);
				2: load_settings(1'($urandom), 1'($urandom), 8'($urandom), 16'($urandom));
				3: load_settings(1'b1, 1'b1, 8'($urandom), 16'($urandom));
				default: load_settings(1'($urandom), 1'($urandom), 8'd255, 16'hffff);
			endcase
			sent = 0;
			useful = 0;
			while (useful < 210) begin
				if (sent % 40 == 0) begin
					tx_idle_en = (phase != 4) && ($urandom_range(0, 2) != 0);
					rx_idle_en = (phase != 4) && ($urandom_range(0, 2) != 0);
				end
				// long receiver hold while words keep coming back to back
				if (phase == 1 && sent == 60) begin
					tx_idle_en = 1'b0;
					hold_off_req = 1'b1;
				end
				// sender pause until the pipeline has fully emptied
				if (phase == 2 && sent == 100)
					drain_results();
				pick_next_item(it);
				present_word(it, 1'b0, none);
				sent++;
				if (it.operation != OP_RESERVED)
					useful++;
			end
		end

		drain_results();
		repeat (6) @(posedge clk);
		if (mismatch_count == 0)
			$display("axis_limit_switch_backoff_top test passed");
		else
			$display("axis_limit_switch_backoff_top test failed");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/lsb_pkg.sv
rtl/lsb_calc.sv
rtl/lsb_fsm.sv
rtl/axis_limit_switch_backoff_top.sv
test/axis_limit_switch_backoff_top_tb.sv
